FILE: hw/rtl/mdcs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdcs_pkg: shared types and constants for the divisor count selector
// Sequencer state type, count width and default value width.
// ----------------------------------------------------------------------------
package mdcs_pkg;

    localparam int VALUE_WIDTH_DEF = 32;
    localparam int CNT_W           = 11;
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    // tally increments: exact square root, ordinary divisor pair
    localparam logic [CNT_W-1:0] ADD_ROOT = CNT_W'(1);
    localparam logic [CNT_W-1:0] ADD_PAIR = CNT_W'(2);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_CHECK,
        ST_FIN
    } t_state;

endpackage

FILE: hw/rtl/max_divisor_count_select_top.sv
`timescale 1ns / 1ps
// sequencing: a value of zero or below goes to the finish state; a positive n is divided by
//   1 to floor(sqrt(n)) + 1 in one shared restoring divider (one quotient bit a cycle)
// throughput: one beat at a time; the input stalls until the result is in the output register
// reset: synchronous active low, clears the sequencer, output valid and the running best
// ----------------------------------------------------------------------------
// max_divisor_count_select_top: running value with the most divisors
// Counts divisors by trial division through a bit-serial divider and keeps
// the best value of the set, larger value winning ties.
// ----------------------------------------------------------------------------
module max_divisor_count_select_top #(
    parameter int VALUE_WIDTH = mdcs_pkg::VALUE_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic signed [VALUE_WIDTH-1:0] i_value,
    input  logic                          i_last,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [mdcs_pkg::CNT_W-1:0]    o_item_divisors,
    output logic signed [VALUE_WIDTH-1:0] o_best_value,
    output logic [mdcs_pkg::CNT_W-1:0]    o_best_divisors,
    output logic                          o_set_done
);

    localparam int W  = VALUE_WIDTH;
    localparam int DW = VALUE_WIDTH / 2 + 1;
    localparam int BW = $clog2(VALUE_WIDTH);
    localparam int CW = mdcs_pkg::CNT_W;

    mdcs_pkg::t_state r_state, n_state;

    logic signed [W-1:0] r_val, n_val;
    logic                r_last, n_last;
    logic [DW-1:0]       r_div, n_div;
    logic [CW-1:0]       r_tally, n_tally;
    logic [W-1:0]        r_dvd, n_dvd;
    logic [W-1:0]        r_quo, n_quo;
    logic [DW-1:0]       r_rem, n_rem;
    logic [BW-1:0]       r_bit, n_bit;

    logic signed [W-1:0] r_best_val, n_best_val;
    logic [CW-1:0]       r_best_cnt, n_best_cnt;
    logic                r_have_best, n_have_best;

    logic                r_out_valid, n_out_valid;
    logic [CW-1:0]       r_out_item, n_out_item;
    logic signed [W-1:0] r_out_best, n_out_best;
    logic [CW-1:0]       r_out_cnt, n_out_cnt;
    logic                r_out_done, n_out_done;

    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          ge;
    logic [W-1:0]  div_ext;
    logic [CW:0]   sum;
    logic [CW-1:0] add;
    logic          out_free;
    logic          take;
    logic          positive;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mdcs_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
            r_have_best <= 1'b0;
            r_best_val  <= '0;
            r_best_cnt  <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_have_best <= n_have_best;
            r_best_val  <= n_best_val;
            r_best_cnt  <= n_best_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val      <= n_val;
        r_last     <= n_last;
        r_div      <= n_div;
        r_tally    <= n_tally;
        r_dvd      <= n_dvd;
        r_quo      <= n_quo;
        r_rem      <= n_rem;
        r_bit      <= n_bit;
        r_out_item <= n_out_item;
        r_out_best <= n_out_best;
        r_out_cnt  <= n_out_cnt;
        r_out_done <= n_out_done;
    end

    // restoring divider step, one quotient bit per cycle
    assign trial   = {r_rem, r_dvd[W-1]};
    assign diff    = trial - {1'b0, r_div};
    assign ge      = (trial >= {1'b0, r_div});
    assign div_ext = {{(W-DW){1'b0}}, r_div};
    assign add     = (r_quo == div_ext) ? mdcs_pkg::ADD_ROOT : mdcs_pkg::ADD_PAIR;
    assign sum     = {1'b0, r_tally} + {1'b0, add};

    assign out_free = !r_out_valid || !i_out_stall;
    assign positive = !i_value[W-1] && (i_value != '0);

    assign take = !r_have_best || (r_tally > r_best_cnt)
               || ((r_tally == r_best_cnt) && (r_val > r_best_val));

    always_comb begin
        n_state     = r_state;
        n_val       = r_val;
        n_last      = r_last;
        n_div       = r_div;
        n_tally     = r_tally;
        n_dvd       = r_dvd;
        n_quo       = r_quo;
        n_rem       = r_rem;
        n_bit       = r_bit;
        n_best_val  = r_best_val;
        n_best_cnt  = r_best_cnt;
        n_have_best = r_have_best;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_item  = r_out_item;
        n_out_best  = r_out_best;
        n_out_cnt   = r_out_cnt;
        n_out_done  = r_out_done;
        o_in_stall  = 1'b1;

        case (r_state)
            mdcs_pkg::ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    n_val   = i_value;
                    n_last  = i_last;
                    n_div   = DW'(1);
                    n_tally = '0;
                    n_dvd   = i_value;
                    n_quo   = '0;
                    n_rem   = '0;
                    n_bit   = BW'(W - 1);
                    n_state = positive ? mdcs_pkg::ST_DIV : mdcs_pkg::ST_FIN;
                end
            end
            mdcs_pkg::ST_DIV: begin
                n_dvd = {r_dvd[W-2:0], 1'b0};
                n_quo = {r_quo[W-2:0], ge};
                n_rem = ge ? diff[DW-1:0] : trial[DW-1:0];
                n_bit = r_bit - BW'(1);
                if (r_bit == '0) begin
                    n_state = mdcs_pkg::ST_CHECK;
                end
            end
            mdcs_pkg::ST_CHECK: begin
                if (div_ext > r_quo) begin
                    n_state = mdcs_pkg::ST_FIN;
                end else begin
                    if (r_rem == '0) begin
                        n_tally = sum[CW] ? mdcs_pkg::CNT_MAX : sum[CW-1:0];
                    end
                    n_div   = r_div + DW'(1);
                    n_dvd   = r_val;
                    n_quo   = '0;
                    n_rem   = '0;
                    n_bit   = BW'(W - 1);
                    n_state = mdcs_pkg::ST_DIV;
                end
            end
            mdcs_pkg::ST_FIN: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_item  = r_tally;
                    n_out_done  = r_last;
                    n_out_best  = take ? r_val : r_best_val;
                    n_out_cnt   = take ? r_tally : r_best_cnt;
                    if (r_last) begin
                        n_have_best = 1'b0;
                        n_best_val  = '0;
                        n_best_cnt  = '0;
                    end else if (take) begin
                        n_have_best = 1'b1;
                        n_best_val  = r_val;
                        n_best_cnt  = r_tally;
                    end
                    n_state = mdcs_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = mdcs_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_out_valid     = r_out_valid;
    assign o_item_divisors = r_out_item;
    assign o_best_value    = r_out_best;
    assign o_best_divisors = r_out_cnt;
    assign o_set_done      = r_out_done;

`ifndef NO_ASSERTIONS
    a_best_covers_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_best_divisors >= o_item_divisors))
        else $error("best count below item count");

    a_no_zero_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mdcs_pkg::ST_DIV) |-> (r_div != '0))
        else $error("trial divisor is zero");

    a_set_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mdcs_pkg::ST_FIN && out_free && r_last) |=> !r_have_best)
        else $error("best not cleared after last beat");

    a_nonpos_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mdcs_pkg::ST_FIN && !(r_val > 0)) |-> (r_tally == '0))
        else $error("non-positive value with divisors");
`endif

endmodule
